@@ rtl/core/alpe_pkg.sv @@
package alpe_pkg;

    // Operation codes carried by the op field.
    localparam logic OP_PIXEL = 1'b0;
    localparam logic OP_LATCH = 1'b1;

    localparam int PIXEL_BITS  = 24;
    localparam int BIT_CNT_W   = $clog2(PIXEL_BITS);
    localparam int TIME_W      = 10;
    localparam int DUR_W       = 16;
    localparam int QUEUE_DEPTH = 2;
    localparam int ADDR_W      = 5;
    localparam int DATA_W      = 32;

    // Register indexes, taken from paddr[4:2].
    typedef enum logic [2:0] {
        REG_ZERO_HIGH = 3'd0,
        REG_ZERO_LOW  = 3'd1,
        REG_ONE_HIGH  = 3'd2,
        REG_ONE_LOW   = 3'd3,
        REG_LATCH_GAP = 3'd4
    } t_reg_idx;

    localparam logic [TIME_W-1:0] ZERO_HIGH_RST = TIME_W'(30);
    localparam logic [TIME_W-1:0] ZERO_LOW_RST  = TIME_W'(90);
    localparam logic [TIME_W-1:0] ONE_HIGH_RST  = TIME_W'(90);
    localparam logic [TIME_W-1:0] ONE_LOW_RST   = TIME_W'(30);
    localparam logic [DUR_W-1:0]  LATCH_GAP_RST = DUR_W'(8000);

    typedef struct packed {
        logic                  op;
        logic [PIXEL_BITS-1:0] pixel;
    } t_item;

    typedef struct packed {
        logic [TIME_W-1:0] zero_high;
        logic [TIME_W-1:0] zero_low;
        logic [TIME_W-1:0] one_high;
        logic [TIME_W-1:0] one_low;
        logic [DUR_W-1:0]  latch_gap;
    } t_timing;

    // A segment length of zero is raised to one.
    function automatic logic [DUR_W-1:0] at_least_one(input logic [DUR_W-1:0] v);
        return (v == '0) ? DUR_W'(1) : v;
    endfunction

endpackage

@@ rtl/core/alpe_front.sv @@
module alpe_front #(
    parameter int QueueDepth = alpe_pkg::QUEUE_DEPTH
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic                           i_op,
    input  logic [7:0]                     i_green,
    input  logic [7:0]                     i_red,
    input  logic [7:0]                     i_blue,
    output logic                           o_q_valid,
    output alpe_pkg::t_item                o_q_item,
    input  logic                           i_q_pop
);
    import alpe_pkg::*;

    localparam int PTR_W = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
    localparam int CNT_W = $clog2(QueueDepth + 1);

    t_item              r_mem [QueueDepth];
    logic [PTR_W-1:0]   r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0]   r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0]   r_count,  n_count;
    logic               push;
    logic               pop;
    t_item              in_item;

    assign busy      = (r_count == CNT_W'(QueueDepth));
    assign push      = start && !busy;
    assign o_q_valid = (r_count != '0);
    assign pop       = i_q_pop && o_q_valid;
    assign o_q_item  = r_mem[r_rd_ptr];

    // A latch request carries no colour; its pixel bits are cleared.
    always_comb begin
        in_item.op    = i_op;
        in_item.pixel = (i_op == OP_LATCH) ? '0 : {i_green, i_red, i_blue};
    end

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(QueueDepth - 1)) ? '0 : r_wr_ptr + PTR_W'(1);
        end
        if (pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(QueueDepth - 1)) ? '0 : r_rd_ptr + PTR_W'(1);
        end
        if (push && !pop) begin
            n_count = r_count + CNT_W'(1);
        end else if (pop && !push) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= in_item;
        end
    end

endmodule

@@ rtl/core/alpe_back.sv @@
module alpe_back (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  alpe_pkg::t_timing            i_timing,
    input  logic                         i_q_valid,
    input  alpe_pkg::t_item              i_q_item,
    output logic                         o_q_pop,
    output logic                         o_valid,
    output logic                         o_pin_level,
    output logic [alpe_pkg::DUR_W-1:0]   o_duration_cycles,
    output logic                         o_last_segment
);
    import alpe_pkg::*;

    logic                  r_active;
    logic                  r_is_latch;
    logic                  r_phase_low;
    logic [BIT_CNT_W-1:0]  r_bit_cnt;
    logic [PIXEL_BITS-1:0] r_shift;

    logic                  r_valid;
    logic                  r_level;
    logic [DUR_W-1:0]      r_dur;
    logic                  r_last;

    logic                  done;
    logic                  load;
    logic                  bit_one;
    logic                  seg_level;
    logic [DUR_W-1:0]      seg_dur;
    logic                  seg_last;
    logic                  final_bit;

    assign bit_one   = r_shift[PIXEL_BITS-1];
    assign final_bit = (r_bit_cnt == BIT_CNT_W'(PIXEL_BITS - 1));
    assign done      = r_active && (r_is_latch || (r_phase_low && final_bit));
    assign load      = i_q_valid && (!r_active || done);
    assign o_q_pop   = load;

    always_comb begin
        if (r_is_latch) begin
            seg_level = 1'b0;
            seg_dur   = at_least_one(i_timing.latch_gap);
            seg_last  = 1'b1;
        end else if (!r_phase_low) begin
            seg_level = 1'b1;
            seg_dur   = at_least_one(DUR_W'(bit_one ? i_timing.one_high
                                                    : i_timing.zero_high));
            seg_last  = 1'b0;
        end else begin
            seg_level = 1'b0;
            seg_dur   = at_least_one(DUR_W'(bit_one ? i_timing.one_low
                                                    : i_timing.zero_low));
            seg_last  = final_bit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_valid  <= 1'b0;
        end else begin
            r_valid <= r_active;
            if (load) begin
                r_active <= 1'b1;
            end else if (done) begin
                r_active <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_level <= seg_level;
        r_dur   <= seg_dur;
        r_last  <= seg_last;
        if (load) begin
            r_is_latch  <= (i_q_item.op == OP_LATCH);
            r_shift     <= i_q_item.pixel;
            r_phase_low <= 1'b0;
            r_bit_cnt   <= '0;
        end else if (r_active && !r_is_latch) begin
            r_phase_low <= !r_phase_low;
            if (r_phase_low) begin
                r_shift   <= {r_shift[PIXEL_BITS-2:0], 1'b0};
                r_bit_cnt <= r_bit_cnt + BIT_CNT_W'(1);
            end
        end
    end

    assign o_valid           = r_valid;
    assign o_pin_level       = r_level;
    assign o_duration_cycles = r_dur;
    assign o_last_segment    = r_last;

endmodule

@@ rtl/core/addressable_led_pulse_encoder.sv @@
// Channel   Direction  Handshake                 Payload
// ------    ---------  ------------------------  -------------------------------------
// item      in         start high, busy low      i_op, i_green, i_red, i_blue
// segment   out        o_valid, one cycle        o_pin_level, o_duration_cycles,
//                                                o_last_segment
// config    in         psel/penable/pwrite       paddr, pwdata, prdata, pready
//
// The back end emits one segment per cycle while the queue holds items: a pixel gives 48 segments, a latch request 1.
// Results appear in the cycle after the back end forms them, from the output register.
// A queue of QueueDepth transactions sits between front and back; busy is high while full.
// Reset is synchronous and active low; it empties the queue and loads the default timings.
// The receiver cannot stall, so segments are never held back once formed.
module addressable_led_pulse_encoder #(
    parameter int QueueDepth = alpe_pkg::QUEUE_DEPTH
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic                          i_op,
    input  logic [7:0]                    i_green,
    input  logic [7:0]                    i_red,
    input  logic [7:0]                    i_blue,
    output logic                          o_valid,
    output logic                          o_pin_level,
    output logic [alpe_pkg::DUR_W-1:0]    o_duration_cycles,
    output logic                          o_last_segment,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [alpe_pkg::ADDR_W-1:0]   paddr,
    input  logic [alpe_pkg::DATA_W-1:0]   pwdata,
    output logic [alpe_pkg::DATA_W-1:0]   prdata,
    output logic                          pready
);
    import alpe_pkg::*;

    t_timing  r_timing;
    t_reg_idx reg_idx;
    logic     cfg_wr;
    logic     q_valid;
    t_item    q_item;
    logic     q_pop;

    assign pready  = 1'b1;
    assign reg_idx = t_reg_idx'(paddr[ADDR_W-1:2]);
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timing.zero_high <= ZERO_HIGH_RST;
            r_timing.zero_low  <= ZERO_LOW_RST;
            r_timing.one_high  <= ONE_HIGH_RST;
            r_timing.one_low   <= ONE_LOW_RST;
            r_timing.latch_gap <= LATCH_GAP_RST;
        end else if (cfg_wr) begin
            case (reg_idx)
                REG_ZERO_HIGH: r_timing.zero_high <= pwdata[TIME_W-1:0];
                REG_ZERO_LOW:  r_timing.zero_low  <= pwdata[TIME_W-1:0];
                REG_ONE_HIGH:  r_timing.one_high  <= pwdata[TIME_W-1:0];
                REG_ONE_LOW:   r_timing.one_low   <= pwdata[TIME_W-1:0];
                REG_LATCH_GAP: r_timing.latch_gap <= pwdata[DUR_W-1:0];
                default:       ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_ZERO_HIGH: prdata = DATA_W'(r_timing.zero_high);
            REG_ZERO_LOW:  prdata = DATA_W'(r_timing.zero_low);
            REG_ONE_HIGH:  prdata = DATA_W'(r_timing.one_high);
            REG_ONE_LOW:   prdata = DATA_W'(r_timing.one_low);
            REG_LATCH_GAP: prdata = DATA_W'(r_timing.latch_gap);
            default:       prdata = '0;
        endcase
    end

    alpe_front #(
        .QueueDepth (QueueDepth)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .start     (start),
        .busy      (busy),
        .i_op      (i_op),
        .i_green   (i_green),
        .i_red     (i_red),
        .i_blue    (i_blue),
        .o_q_valid (q_valid),
        .o_q_item  (q_item),
        .i_q_pop   (q_pop)
    );

    alpe_back u_back (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_timing          (r_timing),
        .i_q_valid         (q_valid),
        .i_q_item          (q_item),
        .o_q_pop           (q_pop),
        .o_valid           (o_valid),
        .o_pin_level       (o_pin_level),
        .o_duration_cycles (o_duration_cycles),
        .o_last_segment    (o_last_segment)
    );

endmodule

@@ dv/alpe_checker.sv @@
`timescale 1ns / 1ps

module alpe_checker (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    input  logic                              i_busy,
    input  logic                              i_op,
    input  logic [7:0]                        i_green,
    input  logic [7:0]                        i_red,
    input  logic [7:0]                        i_blue,
    input  logic                              i_valid,
    input  logic                              i_pin_level,
    input  logic [alpe_pkg::DUR_W-1:0]        i_duration_cycles,
    input  logic                              i_last_segment,
    input  logic                              i_psel,
    input  logic                              i_penable,
    input  logic                              i_pwrite,
    input  logic [alpe_pkg::ADDR_W-1:0]       i_paddr,
    input  logic [alpe_pkg::DATA_W-1:0]       i_pwdata,
    input  logic                              i_pready,
    output int                                o_fail_count,
    output int                                o_pending
);
    import alpe_pkg::*;

    typedef struct packed {
        logic             level;
        logic [DUR_W-1:0] cycles;
        logic             last;
    } t_segment;

    t_segment segment_q[$];
    t_timing  timing;
    int       mismatches = 0;
    int       seen_count = 0;

    // A programmed length of zero is still predicted as a length of one.
    function automatic logic [DUR_W-1:0] hold_cycles(input logic [DUR_W-1:0] programmed);
        return (programmed != '0) ? programmed : DUR_W'(1);
    endfunction

    task automatic predict_segments(input logic op, input logic [PIXEL_BITS-1:0] pixel);
        logic [DUR_W-1:0] high_len;
        logic [DUR_W-1:0] low_len;
        begin
            if (op == OP_LATCH) begin
                segment_q.push_back({1'b0, hold_cycles(timing.latch_gap), 1'b1});
            end else begin
                // Green sits in the top byte, so walking down from the top bit
                // sends green, red, blue, each most significant bit first.
                for (int k = PIXEL_BITS - 1; k >= 0; k--) begin
                    if (pixel[k]) begin
                        high_len = DUR_W'(timing.one_high);
                        low_len  = DUR_W'(timing.one_low);
                    end else begin
                        high_len = DUR_W'(timing.zero_high);
                        low_len  = DUR_W'(timing.zero_low);
                    end
                    segment_q.push_back({1'b1, hold_cycles(high_len), 1'b0});
                    segment_q.push_back({1'b0, hold_cycles(low_len), (k == 0)});
                end
            end
        end
    endtask

    always @(posedge i_clk) begin
        t_segment want;
        if (!i_rst_n) begin
            timing.zero_high = ZERO_HIGH_RST;
            timing.zero_low  = ZERO_LOW_RST;
            timing.one_high  = ONE_HIGH_RST;
            timing.one_low   = ONE_LOW_RST;
            timing.latch_gap = LATCH_GAP_RST;
            segment_q.delete();
        end else begin
            if (i_valid) begin
                seen_count++;
                if (segment_q.size() == 0) begin
                    $display("%0t: unexpected segment level %0b cycles %0d last %0b",
                             $time, i_pin_level, i_duration_cycles, i_last_segment);
                    mismatches++;
                end else begin
                    want = segment_q.pop_front();
                    if (i_pin_level !== want.level) begin
                        $display("%0t: segment %0d pin_level expected %0b got %0b",
                                 $time, seen_count, want.level, i_pin_level);
                        mismatches++;
                    end
                    if (i_duration_cycles !== want.cycles) begin
                        $display("%0t: segment %0d duration_cycles expected %0d got %0d",
                                 $time, seen_count, want.cycles, i_duration_cycles);
                        mismatches++;
                    end
                    if (i_last_segment !== want.last) begin
                        $display("%0t: segment %0d last_segment expected %0b got %0b",
                                 $time, seen_count, want.last, i_last_segment);
                        mismatches++;
                    end
                end
            end
            if (i_start && !i_busy) begin
                predict_segments(i_op, {i_green, i_red, i_blue});
            end
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                case (t_reg_idx'(i_paddr[ADDR_W-1:2]))
                    REG_ZERO_HIGH: timing.zero_high = i_pwdata[TIME_W-1:0];
                    REG_ZERO_LOW:  timing.zero_low  = i_pwdata[TIME_W-1:0];
                    REG_ONE_HIGH:  timing.one_high  = i_pwdata[TIME_W-1:0];
                    REG_ONE_LOW:   timing.one_low   = i_pwdata[TIME_W-1:0];
                    REG_LATCH_GAP: timing.latch_gap = i_pwdata[DUR_W-1:0];
                    default: ;
                endcase
            end
        end
        o_fail_count <= mismatches;
        o_pending    <= segment_q.size();
    end

endmodule

@@ dv/tb.sv @@
`timescale 1ns / 1ps

module tb;
    import alpe_pkg::*;

    localparam int CYCLE_LIMIT   = 400000;
    localparam int SETTLE_CYCLES = 8;
    localparam int RANDOM_PHASES = 5;
    localparam int PHASE_ITEMS   = 60;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                start = 1'b0;
    logic                busy;
    logic                i_op = OP_PIXEL;
    logic [7:0]          i_green = '0;
    logic [7:0]          i_red = '0;
    logic [7:0]          i_blue = '0;
    logic                o_valid;
    logic                o_pin_level;
    logic [DUR_W-1:0]    o_duration_cycles;
    logic                o_last_segment;
    logic                psel = 1'b0;
    logic                penable = 1'b0;
    logic                pwrite = 1'b0;
    logic [ADDR_W-1:0]   paddr = '0;
    logic [DATA_W-1:0]   pwdata = '0;
    logic [DATA_W-1:0]   prdata;
    logic                pready;
    int                  fail_count;
    int                  pending;
    int                  cycle_count = 0;

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    addressable_led_pulse_encoder dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_op(i_op), .i_green(i_green), .i_red(i_red), .i_blue(i_blue),
        .o_valid(o_valid), .o_pin_level(o_pin_level),
        .o_duration_cycles(o_duration_cycles), .o_last_segment(o_last_segment),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    alpe_checker segment_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(start), .i_busy(busy),
        .i_op(i_op), .i_green(i_green), .i_red(i_red), .i_blue(i_blue),
        .i_valid(o_valid), .i_pin_level(o_pin_level),
        .i_duration_cycles(o_duration_cycles), .i_last_segment(o_last_segment),
        .i_psel(psel), .i_penable(penable), .i_pwrite(pwrite), .i_paddr(paddr),
        .i_pwdata(pwdata), .i_pready(pready),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("** addressable_led_pulse_encoder: FAILED **");
            $finish;
        end
    end

    // Holds the transaction on the pins until the block takes it.
    task automatic send(input logic op, input logic [7:0] g, input logic [7:0] r,
                        input logic [7:0] b);
        @(negedge i_clk);
        start   <= 1'b1;
        i_op    <= op;
        i_green <= g;
        i_red   <= r;
        i_blue  <= b;
        do @(posedge i_clk); while (busy);
    endtask

    task automatic pause_sender(input int cycles);
        @(negedge i_clk);
        start <= 1'b0;
        repeat (cycles - 1) @(negedge i_clk);
    endtask

    // Stops sending and waits for every predicted segment to come out.
    task automatic drain();
        @(negedge i_clk);
        start <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic cfg_write(input logic [2:0] idx, input logic [DATA_W-1:0] value);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic cfg_write_all(input logic [DATA_W-1:0] value);
        for (int r = REG_ZERO_HIGH; r <= REG_LATCH_GAP; r++) begin
            cfg_write(3'(r), value);
        end
    endtask

    // Favors the edges of the legal range; unused upper bits carry noise.
    function automatic logic [DATA_W-1:0] pick_timing(input int width);
        logic [DATA_W-1:0] field_max;
        logic [DATA_W-1:0] value;
        field_max = (DATA_W'(1) << width) - 1;
        case ($urandom_range(0, 7))
            0:       value = '0;
            1:       value = DATA_W'(1);
            2:       value = field_max;
            default: value = DATA_W'($urandom_range(1, field_max));
        endcase
        return ($urandom & ~field_max) | value;
    endfunction

    function automatic logic [7:0] pick_byte();
        case ($urandom_range(0, 9))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return 8'($urandom);
        endcase
    endfunction

    initial begin
        int burst_left;
        int gap;
        logic op;
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Default timings straight out of reset.
        send(OP_PIXEL, 8'h00, 8'h00, 8'h00);
        send(OP_PIXEL, 8'hFF, 8'hFF, 8'hFF);
        send(OP_PIXEL, 8'hAA, 8'h55, 8'h0F);
        send(OP_PIXEL, 8'h80, 8'h01, 8'h3C);
        send(OP_LATCH, 8'hFF, 8'hFF, 8'hFF);
        send(OP_LATCH, 8'h00, 8'h00, 8'h00);
        drain();

        // Zero in every register must still give segments of length one.
        cfg_write_all('0);
        send(OP_PIXEL, 8'hC3, 8'h81, 8'h7E);
        send(OP_LATCH, 8'h5A, 8'hA5, 8'h3C);
        drain();

        cfg_write_all('1);
        send(OP_PIXEL, 8'h5A, 8'hA5, 8'hF0);
        send(OP_LATCH, 8'h0F, 8'hF0, 8'hFF);
        drain();

        // Addresses past the register list must not disturb the timings.
        cfg_write_all(DATA_W'(1));
        for (int r = REG_LATCH_GAP + 1; r < (1 << $bits(t_reg_idx)); r++) begin
            cfg_write(3'(r), DATA_W'($urandom));
        end
        send(OP_PIXEL, 8'h01, 8'h80, 8'hFF);
        send(OP_LATCH, 8'h00, 8'hFF, 8'h00);
        send(OP_PIXEL, 8'h7F, 8'hFE, 8'h00);

        burst_left = $urandom_range(1, 12);
        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            drain();
            for (int r = REG_ZERO_HIGH; r <= REG_LATCH_GAP; r++) begin
                cfg_write(3'(r), pick_timing((r == REG_LATCH_GAP) ? DUR_W : TIME_W));
            end
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                op = ($urandom_range(0, 5) == 0) ? OP_LATCH : OP_PIXEL;
                send(op, pick_byte(), pick_byte(), pick_byte());
                burst_left--;
                if (burst_left == 0) begin
                    burst_left = $urandom_range(1, 12);
                    gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 80);
                    if (gap > 0) begin
                        pause_sender(gap);
                    end
                end
            end
        end
        drain();

        if (fail_count == 0) begin
            $display("** addressable_led_pulse_encoder: PASSED **");
        end else begin
            $display("** addressable_led_pulse_encoder: FAILED **");
        end
        $finish;
    end

endmodule

@@ sim.f @@
rtl/core/alpe_pkg.sv
rtl/core/alpe_front.sv
rtl/core/alpe_back.sv
rtl/core/addressable_led_pulse_encoder.sv
dv/alpe_checker.sv
dv/tb.sv
